// File: rtl/core/msc_pkg.sv
`default_nettype none

package msc_pkg;

  localparam int SAMPLE_W         = 12;
  localparam int WINDOW_DEPTH_DEF = 96;
  localparam int CFG_IDX_W        = 1;

  localparam logic signed [SAMPLE_W-1:0] WINTER_BELOW_RST = 12'sd192;
  localparam logic signed [SAMPLE_W-1:0] SUMMER_ABOVE_RST = 12'sd288;

  localparam logic [CFG_IDX_W-1:0] REG_WINTER_BELOW = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUMMER_ABOVE = 1'd1;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;

  typedef enum logic [1:0] {
    SEASON_WINTER = 2'd0,
    SEASON_SUMMER = 2'd1,
    SEASON_INTER  = 2'd2
  } season_t;

  typedef struct packed {
    logic                       func;
    logic signed [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] average;
    logic                       avg_valid;
    logic [1:0]                 season;
    logic                       changed;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // latch input item, read oldest window entry
    logic upd;        // write sample, adjust sum and pointer
    logic div_start;  // start divider, register threshold products
    logic finish;     // load result register, commit season
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_func;
    logic cnt_zero;
    logic div_done;
  } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/core/msc_ram.sv
`default_nettype none

module msc_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 96,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/msc_div.sv
`default_nettype none

// restoring divider, one quotient bit per cycle
module msc_div #(
  parameter int DW = 19,
  parameter int VW = 7
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic      [DW-1:0] quotient,
  output logic               done
);

  localparam int CW = (DW > 1) ? $clog2(DW) : 1;

  logic          busy;
  logic [CW-1:0] cnt;
  logic [VW-1:0] rem;
  logic [VW-1:0] dvs;
  logic [DW-1:0] q;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          ge;
  logic          last;

  assign trial    = {rem, q[DW-1]};
  assign ge       = trial >= {1'b0, dvs};
  assign diff     = trial - {1'b0, dvs};
  assign last     = cnt == CW'(DW - 1);
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && last;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[VW-1:0] : trial[VW-1:0];
      q   <= {q[DW-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/msc_datapath.sv
`default_nettype none

module msc_datapath import msc_pkg::*; #(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire in_item_t             in_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [SAMPLE_W-1:0]  cfg_data,
  input  wire dp_cmd_t              cmd,
  output dp_status_t                status,
  output out_item_t                 out_data
);

  localparam int PTR_W  = $clog2(WINDOW_DEPTH);
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = SAMPLE_W + PTR_W;
  localparam int PROD_W = SAMPLE_W + CNT_W + 1;

  logic                       func_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic signed [SUM_W-1:0]    sum;
  logic [PTR_W-1:0]           ptr;
  logic                       full;
  season_t                    season;
  logic signed [SAMPLE_W-1:0] winter;
  logic signed [SAMPLE_W-1:0] summer;
  logic signed [PROD_W-1:0]   lo_r;
  logic signed [PROD_W-1:0]   hi_r;

  logic [SAMPLE_W-1:0]        rdata;
  logic signed [SUM_W-1:0]    old_ext;
  logic [CNT_W-1:0]           count;
  logic signed [CNT_W:0]      count_s;
  logic                       cnt_zero;
  logic [SUM_W-1:0]           sum_mag;
  logic [SUM_W-1:0]           quo;
  logic                       div_done;
  logic [SAMPLE_W-1:0]        avg;
  logic signed [PROD_W-1:0]   sum_x;
  season_t                    season_next;
  logic                       changed;

  msc_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.upd),
    .waddr (ptr),
    .wdata (sample_r),
    .re    (cmd.load),
    .raddr (ptr),
    .rdata (rdata)
  );

  assign sum_mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

  msc_div #(
    .DW (SUM_W),
    .VW (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (sum_mag),
    .divisor  (count),
    .quotient (quo),
    .done     (div_done)
  );

  assign count    = full ? CNT_W'(WINDOW_DEPTH) : CNT_W'(ptr);
  assign count_s  = {1'b0, count};
  assign cnt_zero = count == '0;
  assign old_ext  = full ? SUM_W'($signed(rdata)) : '0;
  // quotient magnitude is at most 2048, so the low bits carry the result
  assign avg      = sum[SUM_W-1] ? -quo[SAMPLE_W-1:0] : quo[SAMPLE_W-1:0];
  assign sum_x    = PROD_W'(sum);

  // winter test first, so crossed thresholds favor winter
  always_comb begin
    if (sum_x < lo_r) begin
      season_next = SEASON_WINTER;
    end else if (sum_x > hi_r) begin
      season_next = SEASON_SUMMER;
    end else begin
      season_next = SEASON_INTER;
    end
  end

  assign changed = (func_r == FUNC_EVAL) && !cnt_zero && (season_next != season);

  assign status.in_func  = in_data.func;
  assign status.cnt_zero = cnt_zero;
  assign status.div_done = div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum    <= '0;
      ptr    <= '0;
      full   <= 1'b0;
      season <= SEASON_INTER;
      winter <= WINTER_BELOW_RST;
      summer <= SUMMER_ABOVE_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WINTER_BELOW: winter <= cfg_data;
          REG_SUMMER_ABOVE: summer <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.upd) begin
        sum <= sum - old_ext + SUM_W'(sample_r);
        if (ptr == PTR_W'(WINDOW_DEPTH - 1)) begin
          ptr  <= '0;
          full <= 1'b1;
        end else begin
          ptr <= ptr + 1'b1;
        end
      end
      if (cmd.finish && changed) begin
        season <= season_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r   <= in_data.func;
      sample_r <= in_data.sample;
    end
    if (cmd.div_start) begin
      lo_r <= winter * count_s;
      hi_r <= summer * count_s;
    end
    if (cmd.finish) begin
      out_data.average   <= cnt_zero ? '0 : avg;
      out_data.avg_valid <= !cnt_zero;
      out_data.season    <= changed ? season_next : season;
      out_data.changed   <= changed;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/msc_ctrl.sv
`default_nettype none

module msc_ctrl import msc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_START,
    ST_DIV,
    ST_FINISH
  } state_t;

  state_t state;
  logic   take;
  logic   slot_free;

  assign in_ready  = state == ST_IDLE;
  assign take      = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    cmd           = '0;
    cmd.load      = take;
    cmd.upd       = state == ST_UPD;
    cmd.div_start = (state == ST_START) && !status.cnt_zero;
    cmd.finish    = (state == ST_FINISH) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (take) begin
            state <= (status.in_func == FUNC_PUSH) ? ST_UPD : ST_START;
          end
        end
        ST_UPD: begin
          state <= ST_START;
        end
        ST_START: begin
          state <= status.cnt_zero ? ST_FINISH : ST_DIV;
        end
        ST_DIV: begin
          if (status.div_done) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (slot_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_take_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    take |=> state != ST_IDLE)
    else $error("controller stayed idle after an input transfer");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> state == ST_DIV)
    else $error("divider finished outside the divide state");

  a_finish_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("result not presented after finish");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.upd, cmd.div_start, cmd.finish}))
    else $error("more than one datapath command at once");
`endif

endmodule

`default_nettype wire

// File: rtl/core/moving_average_season_classifier_unit.sv
`default_nettype none

// channel  | handshake              | payload
// in       | in_valid / in_ready    | in_data (func, sample)
// out      | out_valid / out_ready  | out_data (average, avg_valid, season, changed)
// cfg      | cfg_we                 | cfg_index, cfg_data
//
// evaluate item: start, divide and finish states; the divide state waits on the bit-serial divider
// push item: an extra update state writes the ring and adjusts the sum after the window read
// evaluate on an empty window skips the divider
// synchronous reset clears sum, pointer and fill flag, sets season to inter and thresholds to defaults; no ram clear
// a waiting result holds the block in its final state until out_ready

module moving_average_season_classifier_unit import msc_pkg::*; #(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_item_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [SAMPLE_W-1:0]  cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  msc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  msc_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import msc_pkg::*;

  localparam int DEPTH = WINDOW_DEPTH_DEF;
  localparam int DIR_N = 19;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 222;
  localparam int HOLD_CYCLES = 400;

  logic            clk;
  logic            rst;
  logic            in_valid;
  logic            in_ready;
  in_item_t        in_data;
  logic            out_valid;
  logic            out_ready;
  out_item_t       out_data;
  logic            cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SAMPLE_W-1:0]  cfg_data;

  moving_average_season_classifier_unit #(.WINDOW_DEPTH(DEPTH)) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // window model
  int      ring [DEPTH];
  int      ring_sum = 0;
  int      ring_ptr = 0;
  bit      ring_full = 1'b0;
  season_t cur_season = SEASON_INTER;
  int      thr_winter = WINTER_BELOW_RST;
  int      thr_summer = SUMMER_ABOVE_RST;

  out_item_t pending_results [$];
  int        mismatches = 0;
  int        result_count = 0;
  bit        hold_req = 1'b0;
  bit        rx_steady = 1'b0;

  typedef struct packed {
    logic                       func;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       known;
    out_item_t                  want;
  } dir_row_t;

  dir_row_t dir_rows [DIR_N] = '{
    '{FUNC_EVAL, 0, 1'b1, '{0, 1'b0, SEASON_INTER, 1'b0}},
    '{FUNC_PUSH, -2048, 1'b1, '{-2048, 1'b1, SEASON_INTER, 1'b0}},
    '{FUNC_PUSH, 2047, 1'b1, '{0, 1'b1, SEASON_INTER, 1'b0}},
    '{FUNC_EVAL, -1, 1'b1, '{0, 1'b1, SEASON_WINTER, 1'b1}},
    '{FUNC_EVAL, 0, 1'b1, '{0, 1'b1, SEASON_WINTER, 1'b0}},
    '{FUNC_PUSH, 2047, 1'b1, '{682, 1'b1, SEASON_WINTER, 1'b0}},
    '{FUNC_EVAL, 2047, 1'b1, '{682, 1'b1, SEASON_SUMMER, 1'b1}},
    // sum lands exactly on winter_below * count
    '{FUNC_PUSH, -1278, 1'b1, '{192, 1'b1, SEASON_SUMMER, 1'b0}},
    '{FUNC_EVAL, -2048, 1'b1, '{192, 1'b1, SEASON_INTER, 1'b1}},
    // and exactly on summer_above * count
    '{FUNC_PUSH, 672, 1'b1, '{288, 1'b1, SEASON_INTER, 1'b0}},
    '{FUNC_EVAL, 0, 1'b1, '{288, 1'b1, SEASON_INTER, 1'b0}},
    '{FUNC_PUSH, -1, 1'b0, '0},
    '{FUNC_PUSH, -2048, 1'b0, '0},
    '{FUNC_EVAL, 0, 1'b0, '0},
    '{FUNC_PUSH, 0, 1'b0, '0},
    '{FUNC_PUSH, 1365, 1'b0, '0},
    '{FUNC_PUSH, -1366, 1'b0, '0},
    '{FUNC_PUSH, 1, 1'b0, '0},
    '{FUNC_EVAL, -1, 1'b0, '0}
  };

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    #4_000_000;
    $display("moving_average_season_classifier_unit verification failed");
    $finish;
  end

  task automatic report(input string msg);
    $display("MISMATCH: %s", msg);
    mismatches++;
  endtask

  function automatic out_item_t classify_item(input logic f, input logic signed [11:0] s);
    out_item_t r;
    season_t   ns;
    int        cnt;
    int        avg;
    logic      chg;
    chg = 1'b0;
    avg = 0;
    ns = cur_season;
    if (f == FUNC_PUSH) begin
      if (ring_full) ring_sum -= ring[ring_ptr];
      ring[ring_ptr] = s;
      ring_sum += s;
      if (ring_ptr == DEPTH - 1) begin
        ring_ptr = 0;
        ring_full = 1'b1;
      end else begin
        ring_ptr++;
      end
    end
    cnt = ring_full ? DEPTH : ring_ptr;
    if (cnt != 0) begin
      avg = ring_sum / cnt;
      if (f == FUNC_EVAL) begin
        // winter test first, so it wins when thresholds cross
        if (ring_sum < thr_winter * cnt) ns = SEASON_WINTER;
        else if (ring_sum > thr_summer * cnt) ns = SEASON_SUMMER;
        else ns = SEASON_INTER;
        if (ns != cur_season) begin
          cur_season = ns;
          chg = 1'b1;
        end
      end
    end
    r.average = avg[11:0];
    r.avg_valid = (cnt != 0);
    r.season = cur_season;
    r.changed = chg;
    return r;
  endfunction

  function automatic logic signed [11:0] pick_sample();
    int v;
    int spread;
    int mode;
    mode = $urandom_range(0, 15);
    spread = 64 + ((thr_summer > thr_winter) ? thr_summer - thr_winter : thr_winter - thr_summer);
    if (mode < 2) v = int'($urandom_range(0, 4095)) - 2048;
    else if (mode == 2) v = $urandom_range(0, 1) ? 2047 : -2048;
    else if (mode < 5) v = thr_winter;
    else if (mode < 7) v = thr_summer;
    else v = (thr_winter + thr_summer) / 2 + int'($urandom_range(0, 2 * spread)) - spread;
    if (v > 2047) v = 2047;
    if (v < -2048) v = -2048;
    return v[11:0];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 80);
  endfunction

  task automatic send_item(input logic f, input logic signed [11:0] s, input int gap,
                           input bit use_known, input out_item_t known_want);
    in_item_t  item;
    out_item_t want;
    item.func = f;
    item.sample = s;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    want = classify_item(f, s);
    pending_results.push_back(use_known ? known_want : want);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_thresholds(input int w, input int s);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_WINTER_BELOW;
    cfg_data <= w[11:0];
    @(negedge clk);
    cfg_index <= REG_SUMMER_ABOVE;
    cfg_data <= s[11:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    thr_winter = w;
    thr_summer = s;
  endtask

  // receiver side: random stalls, one long hold-off on request
  initial begin : receiver
    int r;
    int stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (rx_steady || r < 70) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 60);
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result transfer %0d", result_count));
      end else begin
        want = pending_results.pop_front();
        if (out_data.average !== want.average)
          report($sformatf("result %0d: average %0d, expected %0d",
                           result_count, out_data.average, want.average));
        if (out_data.avg_valid !== want.avg_valid)
          report($sformatf("result %0d: avg_valid %0b, expected %0b",
                           result_count, out_data.avg_valid, want.avg_valid));
        if (out_data.season !== want.season)
          report($sformatf("result %0d: season %0d, expected %0d",
                           result_count, out_data.season, want.season));
        if (out_data.changed !== want.changed)
          report($sformatf("result %0d: changed %0b, expected %0b",
                           result_count, out_data.changed, want.changed));
      end
      result_count++;
    end
  end

  initial begin : stimulus
    int        thr_w [PHASES];
    int        thr_s [PHASES];
    int        w;
    logic      f;
    logic signed [11:0] s;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = REG_WINTER_BELOW;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_item(dir_rows[i].func, dir_rows[i].sample, pick_gap(),
                dir_rows[i].known, dir_rows[i].want);

    thr_w[0] = -2048; thr_s[0] = 2047;
    thr_w[1] = 2047;  thr_s[1] = -2048;
    thr_w[2] = 0;     thr_s[2] = 0;
    thr_w[3] = WINTER_BELOW_RST; thr_s[3] = SUMMER_ABOVE_RST;
    for (int p = 4; p < PHASES; p++) begin
      w = int'($urandom_range(0, 600)) - 300;
      thr_w[p] = w;
      thr_s[p] = w + int'($urandom_range(0, 300));
    end

    for (int p = 0; p < PHASES; p++) begin
      // config changes only with nothing in flight
      wait_drained();
      set_thresholds(thr_w[p], thr_s[p]);
      rx_steady = (p == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // long receiver hold-off while items keep coming: block fills and stalls input
        if (p == 1 && n == 50) hold_req = 1'b1;
        f = ($urandom_range(0, 2) == 0) ? FUNC_EVAL : FUNC_PUSH;
        s = (f == FUNC_PUSH) ? pick_sample() : 12'($urandom);
        send_item(f, s, (p == 2) ? 0 : pick_gap(), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (40) @(negedge clk);
    if (mismatches == 0)
      $display("moving_average_season_classifier_unit verification clean");
    else
      $display("moving_average_season_classifier_unit verification failed");
    $finish;
  end

endmodule

// File: files.f
rtl/core/msc_pkg.sv
rtl/core/msc_ram.sv
rtl/core/msc_div.sv
rtl/core/msc_datapath.sv
rtl/core/msc_ctrl.sv
rtl/core/moving_average_season_classifier_unit.sv
bench/tb.sv
